// ===== rtl/rgpi_pkg.sv =====
package rgpi_pkg;

  localparam int TEMP_FRAC_BITS = 8;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int WINDOW_DEGREES = 10;

  localparam int ACTION_W = 2;
  localparam int TEMP_W   = 20;
  localparam int ERR_W    = TEMP_W + 1;
  localparam int GAIN_W   = 20;
  localparam int STEP_W   = 16;
  localparam int OUT_W    = 32;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 20;

  localparam int PROD_W = ERR_W + GAIN_W;
  localparam int HIST_W = OUT_W + GAIN_FRAC_BITS;
  localparam int ACC_W  = HIST_W + 2;
  localparam int RND_W  = ACC_W - GAIN_FRAC_BITS;

  localparam logic signed [ERR_W-1:0] WINDOW = ERR_W'(WINDOW_DEGREES << TEMP_FRAC_BITS);
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (GAIN_FRAC_BITS - 1));
  localparam logic signed [RND_W-1:0] OUT_MAX = RND_W'((64'sd1 <<< (OUT_W - 1)) - 1);
  localparam logic signed [RND_W-1:0] OUT_MIN = RND_W'(-(64'sd1 <<< (OUT_W - 1)));

  localparam logic signed [GAIN_W-1:0] DRY_GAIN_NOW_RST   = GAIN_W'(32866);
  localparam logic signed [GAIN_W-1:0] DRY_GAIN_PREV_RST  = GAIN_W'(-32670);
  localparam logic signed [GAIN_W-1:0] DRY_PROP_GAIN_RST  = GAIN_W'(32768);
  localparam logic signed [GAIN_W-1:0] COOK_GAIN_NOW_RST  = GAIN_W'(229415);
  localparam logic signed [GAIN_W-1:0] COOK_GAIN_PREV_RST = GAIN_W'(-229337);
  localparam logic [STEP_W-1:0]        DRY_RAMP_STEP_RST  = STEP_W'(85);
  localparam logic [STEP_W-1:0]        COOK_RAMP_STEP_RST = STEP_W'(205);
  localparam logic signed [TEMP_W-1:0] MODE_THRESHOLD_RST = TEMP_W'(89600);

  typedef enum logic [ACTION_W-1:0] {
    ACT_SAMPLE     = 2'd0,
    ACT_SET_TARGET = 2'd1,
    ACT_ENABLE     = 2'd2,
    ACT_DISABLE    = 2'd3
  } action_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_DRY_PI   = 2'd0,
    MODE_DRY_PROP = 2'd1,
    MODE_COOK_PI  = 2'd2
  } gain_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRY_GAIN_NOW   = 4'd0,
    REG_DRY_GAIN_PREV  = 4'd1,
    REG_DRY_PROP_GAIN  = 4'd2,
    REG_COOK_GAIN_NOW  = 4'd3,
    REG_COOK_GAIN_PREV = 4'd4,
    REG_DRY_RAMP_STEP  = 4'd5,
    REG_COOK_RAMP_STEP = 4'd6,
    REG_MODE_THRESHOLD = 4'd7
  } cfg_reg_t;

endpackage

// ===== rtl/ramped_gain_scheduled_pi.sv =====
// Ramped, gain-scheduled PI temperature controller; reset (rst) is synchronous.
// A control sample is captured in the input register when its request is accepted, then one
// pass of ramp, error and PI math carries it into the result register once that register can take it.
// Throughput: one request per cycle; state updates in the same pass, so samples chain without
// bubbles. Only a stalled, full result register holds input.
// Reset clears valids, history, setpoint, reference and active and loads default registers.
module ramped_gain_scheduled_pi (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [2*rgpi_pkg::TEMP_W-1:0]         s_tdata,   // temperature, target
  input  logic [rgpi_pkg::ACTION_W-1:0]         s_tuser,   // action
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [rgpi_pkg::OUT_W-1:0]            m_tdata,   // control_value
  output logic [rgpi_pkg::MODE_W-1:0]           m_tuser,   // gain_mode
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rgpi_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rgpi_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // configuration
  logic signed [rgpi_pkg::GAIN_W-1:0] dry_gain_now, dry_gain_prev, dry_prop_gain;
  logic signed [rgpi_pkg::GAIN_W-1:0] cook_gain_now, cook_gain_prev;
  logic [rgpi_pkg::STEP_W-1:0]        dry_ramp_step, cook_ramp_step;
  logic signed [rgpi_pkg::TEMP_W-1:0] mode_threshold;

  // controller state
  logic signed [rgpi_pkg::TEMP_W-1:0] setpoint, ramped_reference;
  logic signed [rgpi_pkg::ERR_W-1:0]  previous_error;
  logic signed [rgpi_pkg::OUT_W-1:0]  previous_output;
  logic                               active;

  // input register
  logic                               in_valid;
  rgpi_pkg::action_t                  in_action;
  logic signed [rgpi_pkg::TEMP_W-1:0] in_temp, in_target;

  // result register
  logic                               out_valid;
  logic [rgpi_pkg::OUT_W-1:0]         out_value;
  rgpi_pkg::gain_mode_t               out_mode;

  logic                               has_result, advance;
  logic                               drying, in_window, use_pi;
  logic [rgpi_pkg::STEP_W-1:0]        step;
  logic signed [rgpi_pkg::ERR_W-1:0]  step_s, diff, ramp_sum, ramp_dif;
  logic signed [rgpi_pkg::TEMP_W-1:0] ramp_next;
  logic signed [rgpi_pkg::ERR_W-1:0]  err;
  logic signed [rgpi_pkg::GAIN_W-1:0] g_now, g_prev;
  logic signed [rgpi_pkg::PROD_W-1:0] prod_now, prod_prev;
  logic signed [rgpi_pkg::HIST_W-1:0] hist;
  logic signed [rgpi_pkg::ACC_W-1:0]  acc, acc_r;
  logic signed [rgpi_pkg::RND_W-1:0]  rounded;
  logic signed [rgpi_pkg::OUT_W-1:0]  result;
  rgpi_pkg::gain_mode_t               mode;

  assign cfg_ready = 1'b1;

  assign has_result = in_valid && (in_action == rgpi_pkg::ACT_SAMPLE) && active;
  assign advance    = in_valid && (!has_result || !out_valid || m_tready);
  assign s_tready   = !in_valid || advance;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_value;
  assign m_tuser  = out_mode;

  // ramp limiter
  always_comb begin
    drying   = setpoint < mode_threshold;
    step     = drying ? dry_ramp_step : cook_ramp_step;
    step_s   = $signed({{(rgpi_pkg::ERR_W - rgpi_pkg::STEP_W){1'b0}}, step});
    diff     = rgpi_pkg::ERR_W'(setpoint) - rgpi_pkg::ERR_W'(ramped_reference);
    ramp_sum = rgpi_pkg::ERR_W'(ramped_reference) + step_s;
    ramp_dif = rgpi_pkg::ERR_W'(ramped_reference) - step_s;
    if (diff > 0) begin
      ramp_next = (diff > step_s) ? ramp_sum[rgpi_pkg::TEMP_W-1:0] : setpoint;
    end else begin
      ramp_next = (diff < -step_s) ? ramp_dif[rgpi_pkg::TEMP_W-1:0] : setpoint;
    end
    err       = rgpi_pkg::ERR_W'(ramp_next) - rgpi_pkg::ERR_W'(in_temp);
    in_window = (err < rgpi_pkg::WINDOW) && (err > -rgpi_pkg::WINDOW);
  end

  // gain schedule and PI step
  always_comb begin
    use_pi = !drying || in_window;
    if (!drying) begin
      g_now  = cook_gain_now;
      g_prev = cook_gain_prev;
      mode   = rgpi_pkg::MODE_COOK_PI;
    end else if (in_window) begin
      g_now  = dry_gain_now;
      g_prev = dry_gain_prev;
      mode   = rgpi_pkg::MODE_DRY_PI;
    end else begin
      g_now  = dry_prop_gain;
      g_prev = dry_gain_prev;
      mode   = rgpi_pkg::MODE_DRY_PROP;
    end
    prod_now = rgpi_pkg::PROD_W'(err) * rgpi_pkg::PROD_W'(g_now);
    if (use_pi) begin
      prod_prev = rgpi_pkg::PROD_W'(previous_error) * rgpi_pkg::PROD_W'(g_prev);
      hist      = $signed({previous_output, {rgpi_pkg::GAIN_FRAC_BITS{1'b0}}});
    end else begin
      prod_prev = '0;
      hist      = '0;
    end
    acc       = rgpi_pkg::ACC_W'(prod_now) + rgpi_pkg::ACC_W'(prod_prev)
              + rgpi_pkg::ACC_W'(hist);
    acc_r     = acc + rgpi_pkg::ROUND_HALF;
    rounded   = acc_r[rgpi_pkg::ACC_W-1:rgpi_pkg::GAIN_FRAC_BITS];
    if (rounded > rgpi_pkg::OUT_MAX) begin
      result = rgpi_pkg::OUT_MAX[rgpi_pkg::OUT_W-1:0];
    end else if (rounded < rgpi_pkg::OUT_MIN) begin
      result = rgpi_pkg::OUT_MIN[rgpi_pkg::OUT_W-1:0];
    end else begin
      result = rounded[rgpi_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dry_gain_now     <= rgpi_pkg::DRY_GAIN_NOW_RST;
      dry_gain_prev    <= rgpi_pkg::DRY_GAIN_PREV_RST;
      dry_prop_gain    <= rgpi_pkg::DRY_PROP_GAIN_RST;
      cook_gain_now    <= rgpi_pkg::COOK_GAIN_NOW_RST;
      cook_gain_prev   <= rgpi_pkg::COOK_GAIN_PREV_RST;
      dry_ramp_step    <= rgpi_pkg::DRY_RAMP_STEP_RST;
      cook_ramp_step   <= rgpi_pkg::COOK_RAMP_STEP_RST;
      mode_threshold   <= rgpi_pkg::MODE_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rgpi_pkg::REG_DRY_GAIN_NOW:   dry_gain_now   <= cfg_data;
        rgpi_pkg::REG_DRY_GAIN_PREV:  dry_gain_prev  <= cfg_data;
        rgpi_pkg::REG_DRY_PROP_GAIN:  dry_prop_gain  <= cfg_data;
        rgpi_pkg::REG_COOK_GAIN_NOW:  cook_gain_now  <= cfg_data;
        rgpi_pkg::REG_COOK_GAIN_PREV: cook_gain_prev <= cfg_data;
        rgpi_pkg::REG_DRY_RAMP_STEP:  dry_ramp_step  <= cfg_data[rgpi_pkg::STEP_W-1:0];
        rgpi_pkg::REG_COOK_RAMP_STEP: cook_ramp_step <= cfg_data[rgpi_pkg::STEP_W-1:0];
        rgpi_pkg::REG_MODE_THRESHOLD: mode_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      in_action <= rgpi_pkg::action_t'(s_tuser);
      in_temp   <= s_tdata[rgpi_pkg::TEMP_W-1:0];
      in_target <= s_tdata[2*rgpi_pkg::TEMP_W-1:rgpi_pkg::TEMP_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint         <= '0;
      ramped_reference <= '0;
      previous_error   <= '0;
      previous_output  <= '0;
      active           <= 1'b0;
    end else if (advance) begin
      unique case (in_action)
        rgpi_pkg::ACT_SET_TARGET: begin
          setpoint         <= in_target;
          ramped_reference <= in_temp;
        end
        rgpi_pkg::ACT_ENABLE: begin
          previous_error  <= '0;
          previous_output <= '0;
          active          <= 1'b1;
        end
        rgpi_pkg::ACT_DISABLE: begin
          active <= 1'b0;
        end
        rgpi_pkg::ACT_SAMPLE: begin
          if (active) begin
            ramped_reference <= ramp_next;
            previous_error   <= err;
            previous_output  <= result;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && has_result) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (advance && has_result) begin
      out_value <= result;
      out_mode  <= mode;
    end
  end

endmodule
